### rtl/pas_pkg.sv
package pas_pkg;

  // Sizes of the ready list and of the fields.
  localparam int MAX_TASKS_DEF = 16;
  localparam int NUM_IDS       = 16;
  localparam int ID_W          = 4;
  localparam int PRIO_W        = 7;
  localparam int STEP_W        = 4;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 5;
  localparam int REQ_W         = 2;

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Aged priorities never rise above this value.
  localparam logic signed [PRIO_W-1:0] PRIO_TOP = 7'sd63;

  // Reset values of the configuration registers.
  localparam logic signed [STEP_W-1:0] AGING_STEP_RST = -4'sd1;
  localparam logic signed [PRIO_W-1:0] PRIO_MIN_RST   = -7'sd20;
  localparam logic signed [PRIO_W-1:0] PRIO_MAX_RST   = 7'sd20;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_ENQUEUE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET_PRIO = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SELECT   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_MAX   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // decode and perform enqueue, set-priority or status
    logic age;      // age every entry of the ready list
    logic pick;     // remove the winner of the compare tree
    logic emit;     // load the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_select;  // a select request found a non-empty list
  } dp_stat_t;

endpackage

### rtl/priority_aging_scheduler.sv
// Task scheduler with priority aging. Requests arrive on the slave stream:
// the request kind rides in s_axis_tuser (enqueue, set priority, select) and
// the task id and requested priority in s_axis_tdata. Every request yields
// exactly one result item on the master stream, carrying a status code, the
// chosen task id (zero unless a select succeeded) and the ready-list length.
// The configuration port writes aging step, priority floor and priority
// ceiling; the user must see that it is written only while no request is in
// flight, as the block itself does not enforce this. Enqueue, set-priority
// and an empty select are decoded and go straight to the output register;
// a select that removes an entry also ages the list, waits while the
// registered minimum tree of depth L = clog2(MAX_TASKS) settles, and
// removes the winner. One item is processed at a time; a new item is taken
// in the cycle after the result enters the output register. The output
// register holds a result while the receiver stalls, and the next item can
// already be accepted and worked on behind it. Reset empties the ready
// list, sets every static priority to zero and restores the register
// defaults; no clearing pass is needed.
module priority_aging_scheduler #(
  parameter int MAX_TASKS = pas_pkg::MAX_TASKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, from bit 0: task_id[3:0], priority_req[10:4], zeros above.
  input  logic [pas_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser, from bit 0: req_type[1:0].
  input  logic [pas_pkg::REQ_W-1:0]       s_axis_tuser,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, from bit 0: status[1:0], chosen_task[5:2], ready_count[10:6],
  // zeros above.
  output logic [pas_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // Configuration write port: 0 aging_step, 1 priority_min, 2 priority_max.
  input  logic                            cfg_we,
  input  logic [pas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pas_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pas_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences each request: decode, then for a successful
  // select an aging step, a wait while the compare tree settles and the
  // removal of the winner, and last the loading of the output register.
  pas_ctrl #(
    .MAX_TASKS (MAX_TASKS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the static priority table, the
  // ready list, the minimum tree and the result registers.
  pas_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_user   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_axis_tdata)
  );

endmodule

### rtl/pas_datapath.sv
module pas_datapath #(
  parameter int MAX_TASKS = pas_pkg::MAX_TASKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pas_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [pas_pkg::REQ_W-1:0]       in_user,
  input  logic [pas_pkg::IN_DATA_W-1:0]   in_data,
  input  pas_pkg::dp_cmd_t                cmd,
  output pas_pkg::dp_stat_t               stat,
  output logic [pas_pkg::OUT_DATA_W-1:0]  out_data
);
  import pas_pkg::*;

  localparam int L  = $clog2(MAX_TASKS);
  localparam int P  = 1 << L;
  localparam int IW = L;
  localparam int LW = $clog2(MAX_TASKS + 1);

  typedef struct packed {
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic [ID_W-1:0]          id;
    logic [IW-1:0]            idx;
  } node_t;

  logic signed [STEP_W-1:0] aging_step;
  logic signed [PRIO_W-1:0] prio_min;
  logic signed [PRIO_W-1:0] prio_max;

  logic [REQ_W-1:0]         req_type;
  logic [ID_W-1:0]          req_id;
  logic signed [PRIO_W-1:0] req_prio;

  logic signed [PRIO_W-1:0] static_prio [NUM_IDS];
  logic [ID_W-1:0]          ready_ids   [MAX_TASKS];
  logic signed [PRIO_W-1:0] ready_prio  [MAX_TASKS];
  logic [LW-1:0]            len;

  logic [STATUS_W-1:0]      res_status;
  logic [ID_W-1:0]          res_chosen;
  logic [STATUS_W-1:0]      out_status;
  logic [ID_W-1:0]          out_chosen;
  logic [COUNT_W-1:0]       out_count;
  logic [LW+COUNT_W-1:0]    len_wide;

  logic is_full;
  logic is_empty;
  logic in_range;

  node_t leaf [P];
  node_t tree [1:P-1];

  function automatic logic signed [PRIO_W-1:0] age_prio(
    input logic signed [PRIO_W-1:0] p,
    input logic signed [STEP_W-1:0] step,
    input logic signed [PRIO_W-1:0] floor_p
  );
    logic signed [PRIO_W:0] sum;
    logic signed [PRIO_W:0] floor_w;
    logic signed [PRIO_W:0] top_w;
    sum     = {p[PRIO_W-1], p} + {{(PRIO_W + 1 - STEP_W){step[STEP_W-1]}}, step};
    floor_w = {floor_p[PRIO_W-1], floor_p};
    top_w   = {PRIO_TOP[PRIO_W-1], PRIO_TOP};
    if (sum < floor_w) begin
      return floor_p;
    end else if (sum > top_w) begin
      return PRIO_TOP;
    end
    return sum[PRIO_W-1:0];
  endfunction

  // The left operand wins ties, so the earlier entry is kept.
  function automatic node_t pick_min(input node_t a, input node_t b);
    if (a.valid && (!b.valid || a.prio <= b.prio)) begin
      return a;
    end
    return b;
  endfunction

  assign is_full  = (len == LW'(MAX_TASKS));
  assign is_empty = (len == '0);
  assign in_range = (req_prio >= prio_min) && (req_prio <= prio_max);
  assign stat.go_select = (req_type == REQ_SELECT) && !is_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      aging_step <= AGING_STEP_RST;
      prio_min   <= PRIO_MIN_RST;
      prio_max   <= PRIO_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AGING_STEP: aging_step <= cfg_data[STEP_W-1:0];
        CFG_PRIO_MIN:   prio_min   <= cfg_data[PRIO_W-1:0];
        CFG_PRIO_MAX:   prio_max   <= cfg_data[PRIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type <= in_user;
      req_id   <= in_data[ID_W-1:0];
      req_prio <= in_data[ID_W +: PRIO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NUM_IDS; n++) begin
        static_prio[n] <= '0;
      end
    end else if (cmd.exec && req_type == REQ_SET_PRIO && in_range) begin
      static_prio[req_id] <= req_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.exec && req_type == REQ_ENQUEUE && !is_full) begin
      len <= len + 1'b1;
    end else if (cmd.pick) begin
      len <= len - 1'b1;
    end
  end

  // Each entry is written only at its own place: append, priority update,
  // aging, and the shift that closes the gap behind the removed entry.
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_entry
    localparam int NXT = (i < MAX_TASKS - 1) ? i + 1 : i;
    always_ff @(posedge clk) begin
      if (cmd.exec && req_type == REQ_ENQUEUE && !is_full && len == LW'(i)) begin
        ready_ids[i]  <= req_id;
        ready_prio[i] <= static_prio[req_id];
      end
      if (cmd.exec && req_type == REQ_SET_PRIO && in_range && ready_ids[i] == req_id) begin
        ready_prio[i] <= req_prio;
      end
      if (cmd.age) begin
        ready_prio[i] <= age_prio(ready_prio[i], aging_step, prio_min);
      end
      if (cmd.pick && IW'(i) >= tree[1].idx) begin
        ready_ids[i]  <= ready_ids[NXT];
        ready_prio[i] <= ready_prio[NXT];
      end
    end
  end

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < MAX_TASKS) begin : g_used
      assign leaf[j] = '{valid: (LW'(j) < len), prio: ready_prio[j],
                         id: ready_ids[j], idx: IW'(j)};
    end else begin : g_pad
      assign leaf[j] = '{valid: 1'b0, prio: '0, id: '0, idx: IW'(j)};
    end
  end

  // Heap-ordered minimum tree, one register per node; the root settles once
  // a change of the list has passed through every level of the tree.
  for (genvar k = 1; k < P; k++) begin : g_node
    if (2 * k >= P) begin : g_bottom
      always_ff @(posedge clk) begin
        tree[k] <= pick_min(leaf[2 * k - P], leaf[2 * k - P + 1]);
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        tree[k] <= pick_min(tree[2 * k], tree[2 * k + 1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_chosen <= '0;
      case (req_type)
        REQ_ENQUEUE:  res_status <= is_full ? ST_FULL : ST_OK;
        REQ_SET_PRIO: res_status <= in_range ? ST_OK : ST_RANGE;
        REQ_SELECT:   res_status <= is_empty ? ST_EMPTY : ST_OK;
        default:      res_status <= ST_OK;
      endcase
    end
    if (cmd.pick) begin
      res_chosen <= tree[1].id;
    end
  end

  assign len_wide = (LW + COUNT_W)'(len);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_status;
      out_chosen <= res_chosen;
      out_count  <= len_wide[COUNT_W-1:0];
    end
  end

  assign out_data = {{(OUT_DATA_W - STATUS_W - ID_W - COUNT_W){1'b0}},
                     out_count, out_chosen, out_status};

endmodule

### rtl/pas_ctrl.sv
module pas_ctrl #(
  parameter int MAX_TASKS = pas_pkg::MAX_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pas_pkg::dp_stat_t stat,
  output pas_pkg::dp_cmd_t  cmd
);
  import pas_pkg::*;

  localparam int L  = $clog2(MAX_TASKS);
  localparam int CW = $clog2(L + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_AGE,
    S_TREE,
    S_PICK,
    S_DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;

  always_comb begin
    in_ready    = (state == S_IDLE);
    cmd.capture = in_ready && in_valid;
    cmd.exec    = (state == S_DECODE);
    cmd.age     = (state == S_AGE);
    cmd.pick    = (state == S_PICK);
    cmd.emit    = (state == S_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= stat.go_select ? S_AGE : S_DONE;
        end
        S_AGE: begin
          state <= S_TREE;
          cnt   <= '0;
        end
        S_TREE: begin
          if (cnt == CW'(L - 1)) begin
            state <= S_PICK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_PICK: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (cmd.emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
